### design/sltsolve_pkg.sv
`default_nettype none
package sltsolve_pkg;
  localparam int unsigned ROWS_DEF = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_ACC   = 3'd1,
    OP_CSUB  = 3'd2,
    OP_CDIV  = 3'd3,
    OP_READ  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EXEC,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

### design/sltsolve_in_if.sv
`default_nettype none
interface sltsolve_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [9:0]  row;
  logic [9:0]  column;
  logic signed [31:0] value;
  modport source (output valid, opcode, row, column, value, input ready);
  modport sink (input valid, opcode, row, column, value, output ready);
  modport monitor (input valid, ready, opcode, row, column, value);
endinterface
`default_nettype wire

### design/sltsolve_out_if.sv
`default_nettype none
interface sltsolve_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_row;
  logic signed [31:0] out_value;
  logic        divide_by_zero;
  logic        saturated;
  modport source (output valid, out_row, out_value, divide_by_zero, saturated, input ready);
  modport sink (input valid, out_row, out_value, divide_by_zero, saturated, output ready);
  modport monitor (input valid, ready, out_row, out_value, divide_by_zero, saturated);
endinterface
`default_nettype wire

### design/sparse_lower_triangular_solve.sv
`default_nettype none
// Sparse lower-triangular forward substitution, signed Q16.16. Send per row:
// a load of the rhs, one accumulate per off-diagonal nonzero, then a close
// (subtract or subtract-and-divide); a read returns a stored entry. Items are
// taken one at a time: a load writes the store; an accumulate does a store
// read, a multiply and a saturating add; a close-subtract and a read do a
// store read and then put out their result; a close-divide also runs the
// 64-step bit-serial divider, which a zero diagonal skips. Close and read
// give one result transaction, held in the output register until taken; no
// item is accepted while it waits. The store has no reset; read only entries
// already written. Items whose checked index (column for accumulate, row
// otherwise) is >= ROWS, and opcodes 5-7, are dropped without a result.
module sparse_lower_triangular_solve #(
  parameter int unsigned ROWS = sltsolve_pkg::ROWS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  sltsolve_in_if.sink    in_ch,
  sltsolve_out_if.source out_ch
);
  localparam int unsigned AW = $clog2(ROWS);
  localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;
  localparam logic signed [63:0] S32_MAX = 64'sh000000007FFFFFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFFFFFF80000000;

  sltsolve_pkg::state_t st_r, st_nxt;
  logic [2:0]  op_r;
  logic [9:0]  row_r;
  logic [9:0]  col_r;
  logic signed [31:0] val_r;
  logic signed [63:0] sum_r, acc_r;
  logic        clip_r, sumclip_r, dz_r;
  logic        ov_valid_r;
  logic [9:0]  ov_row_r;
  logic [31:0] ov_val_r;
  logic        ov_dz_r, ov_sat_r;
  logic        div_started_r;

  // accept only in idle with no result waiting
  logic accept;
  logic op_ok, idx_ok;
  assign in_ch.ready = (st_r == sltsolve_pkg::ST_IDLE) && !ov_valid_r;
  assign accept = in_ch.valid && in_ch.ready;
  always_comb begin
    op_ok  = in_ch.opcode <= sltsolve_pkg::OP_READ;
    idx_ok = (in_ch.opcode == sltsolve_pkg::OP_ACC) ?
             ({22'd0, in_ch.column} < ROWS) : ({22'd0, in_ch.row} < ROWS);
  end

  // store: accumulate reads the column entry, everything else the row entry
  logic          st_we;
  logic [31:0]   st_wdata, st_rdata;
  logic [AW-1:0] st_waddr, st_raddr;
  assign st_waddr = AW'(row_r);
  assign st_raddr = (op_r == sltsolve_pkg::OP_ACC) ? AW'(col_r) : AW'(row_r);

  sltsolve_store #(.ROWS(ROWS)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // divider works on magnitudes; the sign is restored at the output
  logic        div_start, div_busy, div_done;
  logic [63:0] dq;
  logic [63:0] dm;
  logic [31:0] gm;
  assign dm = acc_r[63] ? (64'd0 - acc_r) : acc_r;
  assign gm = val_r[31] ? (32'd0 - val_r) : val_r;
  sltsolve_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dm), .divisor(gm),
    .busy(div_busy), .done(div_done), .quotient(dq)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sltsolve_pkg::ST_IDLE:
        if (accept && op_ok && idx_ok) begin
          st_nxt = (in_ch.opcode == sltsolve_pkg::OP_LOAD) ? sltsolve_pkg::ST_FIN
                                                           : sltsolve_pkg::ST_RD;
        end
      sltsolve_pkg::ST_RD:   st_nxt = sltsolve_pkg::ST_EXEC;
      sltsolve_pkg::ST_EXEC: begin
        priority case (op_r)
          sltsolve_pkg::OP_ACC:  st_nxt = sltsolve_pkg::ST_FIN;
          sltsolve_pkg::OP_CDIV: st_nxt = sltsolve_pkg::ST_DIV;
          default:               st_nxt = sltsolve_pkg::ST_OUT;
        endcase
      end
      // a zero diagonal leaves the divide state without a divider run
      sltsolve_pkg::ST_DIV:
        if (val_r == 0 || div_done) st_nxt = sltsolve_pkg::ST_OUT;
      sltsolve_pkg::ST_FIN:  st_nxt = sltsolve_pkg::ST_IDLE;
      sltsolve_pkg::ST_OUT:  st_nxt = sltsolve_pkg::ST_IDLE;
      default:               st_nxt = sltsolve_pkg::ST_IDLE;
    endcase
  end

  // shared 64-bit add: accumulate adds product, close subtracts sum from x*2^16
  logic signed [63:0] prod, x_sh, add_a, add_b, add_res;
  logic signed [64:0] add_wide;
  logic               sub_sel;
  logic               add_ovf;
  assign prod    = 64'(val_r) * 64'($signed(st_rdata));
  assign x_sh    = {{16{st_rdata[31]}}, st_rdata, 16'd0};
  assign sub_sel = (op_r != sltsolve_pkg::OP_ACC);
  assign add_a   = sub_sel ? x_sh : sum_r;
  assign add_b   = sub_sel ? sum_r : acc_r;
  assign add_wide = sub_sel ? ({add_a[63], add_a} - {add_b[63], add_b})
                            : ({add_a[63], add_a} + {add_b[63], add_b});
  assign add_ovf = add_wide[64] != add_wide[63];
  always_comb begin
    if (add_ovf) add_res = add_wide[64] ? S64_MIN : S64_MAX;
    else add_res = add_wide[63:0];
  end

  // round half up for subtract close, signed clip of the divide quotient
  logic signed [63:0] rnd;
  logic [63:0]        dqn;
  logic               div_neg;
  assign rnd     = (acc_r >>> 16) + $signed(64'(acc_r[15]));
  assign dqn     = 64'd0 - dq;
  assign div_neg = acc_r[63] != val_r[31];

  logic signed [31:0] res_c;
  logic               res_clip;
  always_comb begin
    res_clip = 1'b0;
    res_c    = '0;
    if (op_r == sltsolve_pkg::OP_CSUB) begin
      if (rnd > S32_MAX) begin res_c = 32'h7FFFFFFF; res_clip = 1'b1; end
      else if (rnd < S32_MIN) begin res_c = 32'h80000000; res_clip = 1'b1; end
      else res_c = rnd[31:0];
    end else if (val_r == 0) begin
      res_c = acc_r[63] ? 32'h80000000 : 32'h7FFFFFFF;
    end else if (!div_neg) begin
      if (dq > 64'h7FFFFFFF) begin res_c = 32'h7FFFFFFF; res_clip = 1'b1; end
      else res_c = dq[31:0];
    end else begin
      if (dq > 64'h80000000) begin res_c = 32'h80000000; res_clip = 1'b1; end
      else res_c = dqn[31:0];
    end
  end

  // outputs: store writes and the divider kick
  always_comb begin
    st_we     = 1'b0;
    st_wdata  = val_r;
    div_start = 1'b0;
    unique case (st_r)
      sltsolve_pkg::ST_FIN: st_we = (op_r == sltsolve_pkg::OP_LOAD);
      sltsolve_pkg::ST_DIV: div_start = !div_started_r && (val_r != 0);
      sltsolve_pkg::ST_OUT: begin
        st_we    = (op_r != sltsolve_pkg::OP_READ);
        st_wdata = res_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= sltsolve_pkg::ST_IDLE;
      sum_r         <= '0;
      sumclip_r     <= 1'b0;
      ov_valid_r    <= 1'b0;
      div_started_r <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      div_started_r <= (st_r == sltsolve_pkg::ST_DIV);
      // hold the result until taken; raise it when leaving the output state
      if (ov_valid_r) ov_valid_r <= !out_ch.ready;
      else ov_valid_r <= (st_r == sltsolve_pkg::ST_OUT);
      if (st_r == sltsolve_pkg::ST_FIN && op_r == sltsolve_pkg::OP_ACC) begin
        sum_r <= add_res;
        if (add_ovf) sumclip_r <= 1'b1;
      end else if (st_r == sltsolve_pkg::ST_OUT && op_r != sltsolve_pkg::OP_READ) begin
        sum_r     <= '0;
        sumclip_r <= 1'b0;
      end
    end
    if (accept) begin
      op_r  <= in_ch.opcode;
      row_r <= in_ch.row;
      col_r <= in_ch.column;
      val_r <= in_ch.value;
    end
    if (st_r == sltsolve_pkg::ST_EXEC) begin
      if (op_r == sltsolve_pkg::OP_ACC) acc_r <= prod;
      else if (op_r == sltsolve_pkg::OP_READ) acc_r <= 64'($signed(st_rdata));
      else acc_r <= add_res;
      clip_r <= add_ovf | sumclip_r;
      dz_r   <= (op_r == sltsolve_pkg::OP_CDIV) && (val_r == 0);
    end
    if (st_r == sltsolve_pkg::ST_OUT) begin
      ov_row_r <= row_r;
      if (op_r == sltsolve_pkg::OP_READ) begin
        ov_val_r <= acc_r[31:0];
        ov_dz_r  <= 1'b0;
        ov_sat_r <= 1'b0;
      end else begin
        ov_val_r <= res_c;
        ov_dz_r  <= dz_r;
        ov_sat_r <= clip_r | res_clip;
      end
    end
  end

  assign out_ch.valid          = ov_valid_r;
  assign out_ch.out_row        = ov_row_r;
  assign out_ch.out_value      = ov_val_r;
  assign out_ch.divide_by_zero = ov_dz_r;
  assign out_ch.saturated      = ov_sat_r;

  // Result transaction appears only after a close or read went through output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_valid_r) |-> $past(st_r == sltsolve_pkg::ST_OUT))
    else $error("result without close or read");
  // Not ready while a result waits
  a_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ov_valid_r |-> !in_ch.ready)
    else $error("accepted while result pending");
  // Divide-by-zero flag only on divide closes
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_by_zero |-> op_r == sltsolve_pkg::OP_CDIV)
    else $error("divide_by_zero on non-divide");
  // Hold a waiting result steady
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.out_row) && $stable(out_ch.out_value))
    else $error("result changed while waiting");
  // Divider runs only inside the divide state
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> st_r == sltsolve_pkg::ST_DIV)
    else $error("divider busy outside divide state");
endmodule
`default_nettype wire

### design/sltsolve_div.sv
`default_nettype none
// Restoring divider, unsigned 64 / 32, one quotient bit per cycle.
module sltsolve_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted  = {rem_r[31:0], q_r[63]};
    trial    = shifted - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

### design/sltsolve_store.sv
`default_nettype none
// Solution vector: one write port, one registered read port.
module sltsolve_store #(
  parameter int unsigned ROWS = sltsolve_pkg::ROWS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(ROWS)-1:0]  waddr,
  input  wire logic [31:0]              wdata,
  input  wire logic [$clog2(ROWS)-1:0]  raddr,
  output logic [31:0]                   rdata
);
  logic [31:0] mem [ROWS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### bench/sltsolve_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module sltsolve_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sltsolve_in_if.monitor  in_mon,
  sltsolve_out_if.monitor out_mon,
  output int              fail_count,
  output int              pending_count
);
  typedef struct packed {
    logic [9:0]  row;
    logic [31:0] value;
    logic        dz;
    logic        sat;
  } solution_t;

  logic signed [31:0] x_mirror [1024];
  logic signed [63:0] sum_mirror;
  logic               clip_mirror;
  solution_t          solutions_due[$];

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v, inout logic c);
    if (v > 64'sd2147483647) begin
      c = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      c = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Advance the mirror by one transaction and queue the solution it reports.
  task automatic solve_step(input logic [2:0] op, input logic [9:0] r,
                            input logic [9:0] c, input logic signed [31:0] v);
    logic signed [64:0]  wide;
    logic signed [63:0]  d;
    logic signed [127:0] q;
    logic signed [31:0]  res;
    logic                clip;
    logic                dz;
    clip = 1'b0;
    dz = 1'b0;
    if (op == sltsolve_pkg::OP_ACC) begin
      wide = 65'(sum_mirror) + 65'(v) * 65'(x_mirror[c]);
      if (wide > 65'(S64_MAX)) begin
        sum_mirror = S64_MAX;
        clip_mirror = 1'b1;
      end else if (wide < 65'(S64_MIN)) begin
        sum_mirror = S64_MIN;
        clip_mirror = 1'b1;
      end else begin
        sum_mirror = wide[63:0];
      end
      return;
    end
    if (op > sltsolve_pkg::OP_READ) return;
    if (op == sltsolve_pkg::OP_LOAD) begin
      x_mirror[r] = v;
      return;
    end
    if (op == sltsolve_pkg::OP_READ) begin
      res = x_mirror[r];
    end else begin
      wide = (65'(x_mirror[r]) <<< 16) - 65'(sum_mirror);
      if (wide > 65'(S64_MAX)) begin
        d = S64_MAX;
        clip = 1'b1;
      end else if (wide < 65'(S64_MIN)) begin
        d = S64_MIN;
        clip = 1'b1;
      end else begin
        d = wide[63:0];
      end
      if (op == sltsolve_pkg::OP_CSUB) begin
        // Floor shift plus half: round to nearest, ties up.
        res = clip32((d >>> 16) + $signed(64'(d[15])), clip);
      end else if (v == 0) begin
        dz = 1'b1;
        res = (d >= 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end else begin
        q = 128'(d) / 128'(v);
        if (q > 128'sd2147483647) begin
          clip = 1'b1;
          res = 32'sh7FFF_FFFF;
        end else if (q < -128'sd2147483648) begin
          clip = 1'b1;
          res = 32'sh8000_0000;
        end else begin
          res = q[31:0];
        end
      end
      clip = clip | clip_mirror;
      x_mirror[r] = res;
      sum_mirror = '0;
      clip_mirror = 1'b0;
    end
    solutions_due.push_back('{row: r, value: res, dz: dz, sat: clip});
  endtask

  always @(posedge clk) begin
    solution_t want;
    if (!rst_n) begin
      sum_mirror = '0;
      clip_mirror = 1'b0;
      solutions_due.delete();
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (solutions_due.size() == 0) begin
          $display("%0t: unexpected result row %0d value %h", $time, out_mon.out_row,
                   out_mon.out_value);
          fail_count <= fail_count + 1;
        end else begin
          want = solutions_due.pop_front();
          if (want.row !== out_mon.out_row || want.value !== out_mon.out_value ||
              want.dz !== out_mon.divide_by_zero || want.sat !== out_mon.saturated) begin
            $display("%0t: expected row %0d value %h dz %b sat %b, got row %0d value %h dz %b sat %b",
                     $time, want.row, want.value, want.dz, want.sat, out_mon.out_row,
                     out_mon.out_value, out_mon.divide_by_zero, out_mon.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        solve_step(in_mon.opcode, in_mon.row, in_mon.column, in_mon.value);
    end
    pending_count <= solutions_due.size();
  end
endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;
  int   idle_cycles = 0;
  logic calm = 1'b0;       // suppress random idling during the quiet stretch
  logic written [1024];    // rows that hold a defined entry

  sltsolve_in_if  in_ch();
  sltsolve_out_if out_ch();

  sparse_lower_triangular_solve u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  sltsolve_checker u_chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                          .fail_count(fail_count), .pending_count(pending_count));

  always #5 clk = ~clk;

  // Receiver backpressure: change ready on the falling edge only.
  always @(negedge clk)
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one transaction and hold it until accepted; maybe idle first.
  // Ready only moves at the rising edge, so checking it at the falling edge
  // tells whether the next rising edge takes the transaction.
  task automatic send(input logic [2:0] op, input logic [9:0] r, input logic [9:0] c,
                      input logic [31:0] v);
    while (!calm && $urandom_range(99) < 25) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.row = r;
    in_ch.column = c;
    in_ch.value = v;
    while (in_ch.ready !== 1'b1) @(negedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
    if (op == sltsolve_pkg::OP_LOAD ||
        ((op == sltsolve_pkg::OP_CSUB || op == sltsolve_pkg::OP_CDIV ||
          op == sltsolve_pkg::OP_READ) && written[r]))
      written[r] = 1'b1;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(8)) - 4) <<< 16;
      3: return 32'($signed($urandom_range(65535)) - 32768);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] pick_written();
    logic [9:0] r;
    do r = 10'($urandom_range(31)); while (!written[r]);
    return r;
  endfunction

  // One well-formed row: load, a few nonzeros from written rows, then close.
  task automatic solve_row(input logic [9:0] r, input logic [2:0] close_op,
                           input logic [31:0] diag);
    int n;
    n = $urandom_range(4);
    send(sltsolve_pkg::OP_LOAD, r, '0, rand_value());
    repeat (n) send(sltsolve_pkg::OP_ACC, '0, pick_written(), rand_value());
    send(close_op, r, '0, diag);
  endtask

  initial begin
    int sent;
    logic [2:0] op;
    in_ch.valid = 1'b0;
    in_ch.opcode = sltsolve_pkg::OP_LOAD;
    in_ch.row = '0;
    in_ch.column = '0;
    in_ch.value = '0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every operation, zero diagonal, ignored items.
    send(sltsolve_pkg::OP_LOAD, 10'd0, '0, 32'h7FFF_FFFF);
    send(sltsolve_pkg::OP_LOAD, 10'd1023, '0, 32'h8000_0000);
    send(sltsolve_pkg::OP_READ, 10'd0, '0, '0);
    send(sltsolve_pkg::OP_READ, 10'd1023, '0, '0);
    send(sltsolve_pkg::OP_ACC, '0, 10'd1023, 32'h7FFF_FFFF);
    send(sltsolve_pkg::OP_ACC, '0, 10'd1023, 32'h7FFF_FFFF);
    send(sltsolve_pkg::OP_ACC, '0, 10'd1023, 32'h7FFF_FFFF);
    send(sltsolve_pkg::OP_CSUB, 10'd0, '0, '0);             // sum clip and result clip
    send(sltsolve_pkg::OP_LOAD, 10'd2, '0, 32'h0001_8000);
    send(sltsolve_pkg::OP_CDIV, 10'd2, '0, 32'h0000_0000);  // zero diagonal, positive
    send(sltsolve_pkg::OP_LOAD, 10'd3, '0, 32'hFFFF_0000);
    send(sltsolve_pkg::OP_CDIV, 10'd3, '0, 32'h0000_0000);  // zero diagonal, negative
    send(sltsolve_pkg::OP_LOAD, 10'd4, '0, 32'h0003_0000);
    send(sltsolve_pkg::OP_ACC, '0, 10'd2, 32'h0000_8000);
    send(sltsolve_pkg::OP_CDIV, 10'd4, '0, 32'hFFFF_FFFF);  // tiny negative diagonal
    send(sltsolve_pkg::OP_LOAD, 10'd5, '0, 32'h0000_0001);
    send(sltsolve_pkg::OP_CSUB, 10'd5, '0, '0);
    send(3'd5, 10'd5, 10'd5, 32'h1234_5678);      // unused opcodes
    send(3'd7, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    send(sltsolve_pkg::OP_CDIV, 10'd1023, '0, 32'h8000_0000);
    send(sltsolve_pkg::OP_READ, 10'd4, '0, '0);

    // Quiet stretch, then hold off until every result has drained.
    calm = 1'b1;
    for (int k = 0; k < 6; k++) solve_row(10'(6 + k), sltsolve_pkg::OP_CSUB, '0);
    while (pending_count != 0) @(negedge clk);
    calm = 1'b0;

    // Random: mostly well-formed rows, some stray reads and noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: send(sltsolve_pkg::OP_READ, pick_written(), 10'($urandom), $urandom);
        1: begin
          op = 3'($urandom_range(5, 7));
          send(op, 10'($urandom), 10'($urandom), $urandom);
        end
        default: begin
          if ($urandom_range(1))
            solve_row(10'($urandom_range(31)), sltsolve_pkg::OP_CSUB, $urandom);
          else
            solve_row(10'($urandom_range(31)), sltsolve_pkg::OP_CDIV,
                      ($urandom_range(7) == 0) ? 32'h0 : rand_value());
          sent += 3;
        end
      endcase
      sent++;
    end

    while (pending_count != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
